/* rtl/positional_list_engine_top_macros.svh */
// Assertion macros used by the checker file.
`ifndef POSITIONAL_LIST_ENGINE_TOP_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_TOP_MACROS_SVH

// Implication checked in the same cycle.
`define PLE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle.
`define PLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/plist_pkg.sv */
package plist_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 6;
  localparam int DATA_W   = 32;
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [1:0] {
    FUNC_READ   = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_REMOVE = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_PREV,
    CELL_FROM_NEXT
  } cell_op_t;

  typedef struct packed {
    logic [1:0]               func;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] data_in;
  } in_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] read_value;
    logic [COUNT_W-1:0]       count;
    logic                     is_empty;
  } out_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] data;
  } ctrl_t;

endpackage

/* rtl/plist_cell.sv */
module plist_cell (
  input  logic                               clk,
  input  plist_pkg::ctrl_t                   ctrl,
  input  logic [plist_pkg::IDX_W-1:0]        cell_idx,
  input  logic signed [plist_pkg::DATA_W-1:0] prev_q,
  input  logic signed [plist_pkg::DATA_W-1:0] next_q,
  output logic signed [plist_pkg::DATA_W-1:0] q,
  output logic signed [plist_pkg::DATA_W-1:0] rd_term
);
  import plist_pkg::*;

  cell_op_t                 cell_op;
  logic signed [DATA_W-1:0] entry_r;
  logic signed [DATA_W-1:0] entry_nxt;

  // Pick this cell's move from the broadcast request
  always_comb begin
    priority if (ctrl.ins && (cell_idx == ctrl.idx)) begin
      cell_op = CELL_LOAD;
    end else if (ctrl.ins && (cell_idx > ctrl.idx)) begin
      cell_op = CELL_FROM_PREV;
    end else if (ctrl.rem && (cell_idx >= ctrl.idx)) begin
      cell_op = CELL_FROM_NEXT;
    end else begin
      cell_op = CELL_HOLD;
    end
  end

  always_comb begin
    unique case (cell_op)
      CELL_LOAD:      entry_nxt = ctrl.data;
      CELL_FROM_PREV: entry_nxt = prev_q;
      CELL_FROM_NEXT: entry_nxt = next_q;
      default:        entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign q       = entry_r;
  // Drive the read bus only when addressed
  assign rd_term = (cell_idx == ctrl.idx) ? entry_r : '0;

endmodule

/* rtl/positional_list_engine_top.sv */
// Positional list engine: keeps an ordered list of up to CAPACITY signed
// 32-bit entries, addressed from position 1, and answers read, insert and
// remove requests with one result transaction each. The chain of entry
// cells shifts the whole tail back (insert) or forward (remove) all at
// once, and the result is registered, so it appears on out_ the cycle
// after the request is accepted. A new request is taken every cycle as
// long as the result register is empty or being drained; only a held
// result (out_valid high, out_ready low) stalls in_. A failed request
// (bad position, full list, unused code) returns ok 0 and read_value -1
// and leaves the list untouched.
module positional_list_engine_top (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  plist_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output plist_pkg::out_t  out_data
);
  import plist_pkg::*;

  logic [CNT_W-1:0]         cnt_r;
  logic [CNT_W-1:0]         cnt_nxt;
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  out_t                     out_data_r;
  out_t                     out_data_nxt;

  logic                     in_fire;
  logic [CMP_W-1:0]         pos_c;
  logic [CMP_W-1:0]         cnt_c;
  logic [POS_W-1:0]         pos_m1;
  logic                     pos_nz;
  logic                     rd_ok;
  logic                     ins_ok;
  logic                     rem_ok;
  logic signed [DATA_W-1:0] rd_value;
  ctrl_t                    ctrl;

  logic signed [DATA_W-1:0] q_w     [CAPACITY];
  logic signed [DATA_W-1:0] prev_w  [CAPACITY];
  logic signed [DATA_W-1:0] next_w  [CAPACITY];
  logic signed [DATA_W-1:0] rd_terms[CAPACITY];

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Check the position against the current fill
  assign pos_c  = CMP_W'(in_data.position);
  assign cnt_c  = CMP_W'(cnt_r);
  assign pos_nz = (in_data.position != '0);
  assign pos_m1 = in_data.position - POS_W'(1);

  always_comb begin
    rd_ok  = 1'b0;
    ins_ok = 1'b0;
    rem_ok = 1'b0;
    unique case (in_data.func)
      FUNC_READ:   rd_ok  = pos_nz && (pos_c <= cnt_c);
      FUNC_INSERT: ins_ok = pos_nz && (pos_c <= cnt_c + CMP_W'(1))
                            && (cnt_c < CMP_W'(CAPACITY));
      FUNC_REMOVE: rem_ok = pos_nz && (pos_c <= cnt_c);
      default: begin
        rd_ok = 1'b0;
      end
    endcase
  end

  // Broadcast the request to the chain
  always_comb begin
    ctrl.ins  = in_fire && ins_ok;
    ctrl.rem  = in_fire && rem_ok;
    ctrl.idx  = IDX_W'(pos_m1);
    ctrl.data = in_data.data_in;
  end

  // Build the chain of entry cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign prev_w[g] = '0;
    end else begin : g_body
      assign prev_w[g] = q_w[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign next_w[g] = q_w[g];
    end else begin : g_link
      assign next_w[g] = q_w[g+1];
    end

    plist_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .cell_idx (IDX_W'(g)),
      .prev_q   (prev_w[g]),
      .next_q   (next_w[g]),
      .q        (q_w[g]),
      .rd_term  (rd_terms[g])
    );
  end

  // Merge the addressed cell onto the read bus
  always_comb begin
    rd_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_value = rd_value | rd_terms[i];
    end
  end

  // Update the fill count and the result
  always_comb begin
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (in_fire) begin
      if (ins_ok) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end else if (rem_ok) begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end
      out_valid_nxt           = 1'b1;
      out_data_nxt.ok         = rd_ok || ins_ok || rem_ok;
      out_data_nxt.read_value = rd_ok ? rd_value
                              : ((ins_ok || rem_ok) ? '0 : '1);
      out_data_nxt.count      = COUNT_W'(cnt_nxt);
      out_data_nxt.is_empty   = (cnt_nxt == '0);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/plist_checker.sv */
`include "positional_list_engine_top_macros.svh"

module plist_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input plist_pkg::in_t  in_data,
  input logic            out_valid,
  input logic            out_ready,
  input plist_pkg::out_t out_data
);
  import plist_pkg::*;

  // Hold a stalled result
  `PLE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_data), "result changed while stalled")

  // Every accepted transaction yields a result next cycle
  `PLE_ASSERT_NEXT(a_one_result, clk, rst_n, in_valid && in_ready,
    out_valid, "accepted transaction produced no result")

  // Empty flag tracks the count
  `PLE_ASSERT_SAME(a_empty_flag, clk, rst_n, out_valid,
    out_data.is_empty == (out_data.count == '0), "empty flag disagrees with count")

  // Failed requests report -1
  `PLE_ASSERT_SAME(a_fail_value, clk, rst_n, out_valid && !out_data.ok,
    out_data.read_value == -32'sd1, "failed request without -1")

  // Count never exceeds the capacity
  `PLE_ASSERT_SAME(a_count_cap, clk, rst_n, out_valid,
    int'(out_data.count) <= CAPACITY, "count above capacity")

  logic unused_in;
  assign unused_in = ^in_data;

endmodule

bind positional_list_engine_top plist_checker u_plist_checker (.*);
